@@ hw/rtl/htw_pkg.sv @@
package htw_pkg;
  localparam int unsigned Slots     = 64;
  localparam int unsigned Entries   = 32;
  localparam int unsigned DelayBits = 20;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned IdxW      = $clog2(Entries);
  localparam int unsigned LinkW     = $clog2(Entries + 1);
  localparam int unsigned StepW     = $clog2(Entries + 1);
  localparam logic [LinkW-1:0] Nil  = LinkW'(Entries);

  typedef enum logic [1:0] {
    KIND_SET     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_QUIET   = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // Entry record kept in the pool memory.
  typedef struct packed {
    logic [LinkW-1:0]     link;
    logic [DelayBits-1:0] rounds;
    logic [31:0]          payload;
  } entry_t;
endpackage

@@ hw/rtl/htw_ram.sv @@
module htw_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hw/rtl/hashed_timing_wheel.sv @@
// Hashed timing wheel. A set request writes its entry into the pool (or finds no free
// entry and reports full) and puts its result in the output register; the input is
// ready again once the result is in that register. A tick walks the current slot list,
// ages kept entries and unlinks expired ones, then moves the pending entries to their
// target slots and puts its last result out. Each expiry after the first may wait for
// the output register. One request is handled at a time.
// After reset a clearing pass empties each of the Slots (64) entries of the slot head
// memory, and no request is accepted until it is done.
module hashed_timing_wheel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [19:0] delay_ticks, [51:20] payload; tuser: opcode
  input  logic [55:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: [5:0] handle, [37:6] expired_payload; tuser: kind
  output logic [39:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);
  import htw_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SET, ST_RESP, ST_HEAD_RD, ST_WALK_RD, ST_WALK_WR,
    ST_UNLINK, ST_PEND_RD, ST_PEND_HD, ST_PEND_WR
  } state_e;

  state_e               state_q, state_d;
  logic [SlotW-1:0]     pos_q, pos_d, clr_q, clr_d, tgt_q, tgt_d;
  logic [LinkW-1:0]     pend_q, pend_d, free_q, free_d, cur_q, cur_d, prev_q, prev_d;
  logic [StepW-1:0]     steps_q, steps_d, fill_q, fill_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [DelayBits-1:0] dly_q, dly_d;
  logic [31:0]          pay_q, pay_d;
  // Record of the last kept walk entry, or of the pending entry being moved.
  entry_t               rec_q, rec_d;

  // The newest expiry of a tick is held back until it is known whether it is
  // the final result; the same registers carry set, full and quiet results.
  logic                 held_q, held_d;
  kind_e                rkind_q, rkind_d;
  logic [IdxW-1:0]      rhand_q, rhand_d;
  logic [31:0]          rpay_q, rpay_d;

  // Output register: one result waiting.
  logic        ov_q, ov_d;
  logic [1:0]  okind_q, okind_d;
  logic [5:0]  ohand_q, ohand_d;
  logic [31:0] opay_q, opay_d;
  logic        olast_q, olast_d;

  // Pool memory.
  logic            ewe;
  logic [IdxW-1:0] ewa, era;
  entry_t          ewd, erd;
  htw_ram #(.Depth(Entries), .Width($bits(entry_t))) u_pool (
    .clk_i, .we_i(ewe), .waddr_i(ewa), .wdata_i(ewd), .raddr_i(era), .rdata_o(erd)
  );

  // Slot head memory.
  logic             swe;
  logic [SlotW-1:0] swa, sra;
  logic [LinkW-1:0] swd, srd;
  htw_ram #(.Depth(Slots), .Width(LinkW)) u_slot (
    .clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd)
  );

  // Entries never allocated since reset still form the tail of the free list in
  // index order; a fill count marks them, so their link reads as index plus one.
  logic [LinkW-1:0] free_link;
  assign free_link = (StepW'(idx_q) >= fill_q) ? LinkW'(idx_q) + LinkW'(1) : erd.link;

  logic out_free, in_acc, walk_go;
  assign out_free = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = {2'b00, opay_q, ohand_q};
  assign m_axis_tuser_o = okind_q;
  assign m_axis_tlast_o = olast_q;

  logic [SlotW-1:0] pos_n, tgt_n;
  logic [SlotW:0]   tsum;
  assign pos_n = (pos_q == SlotW'(Slots - 1)) ? '0 : pos_q + SlotW'(1);
  // Target slot of a pending entry: (delay mod Slots + position) mod Slots.
  assign tsum  = {1'b0, erd.rounds[SlotW-1:0]} + {1'b0, pos_q};
  assign tgt_n = (tsum >= (SlotW+1)'(Slots)) ? SlotW'(tsum - (SlotW+1)'(Slots))
                                             : SlotW'(tsum);

  always_comb begin
    state_d = state_q; pos_d = pos_q; clr_d = clr_q; tgt_d = tgt_q;
    pend_d = pend_q; free_d = free_q; cur_d = cur_q; prev_d = prev_q;
    steps_d = steps_q; fill_d = fill_q; idx_d = idx_q; dly_d = dly_q; pay_d = pay_q;
    rec_d = rec_q; held_d = held_q; rkind_d = rkind_q; rhand_d = rhand_q;
    rpay_d = rpay_q;
    ov_d = ov_q && !m_axis_tready_i;
    okind_d = okind_q; ohand_d = ohand_q; opay_d = opay_q; olast_d = olast_q;
    ewe = 1'b0; ewa = idx_q; ewd = erd; era = idx_q;
    swe = 1'b0; swa = pos_q; swd = Nil; sra = pos_q;
    walk_go = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        swe = 1'b1; swa = clr_q; clr_d = clr_q + SlotW'(1);
        if (clr_q == SlotW'(Slots - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        // The free head and the current slot head are read at the accepting edge.
        era = free_q[IdxW-1:0];
        if (in_acc) begin
          if (s_axis_tuser_i == OP_SET) begin
            if (free_q >= Nil) begin
              rkind_d = KIND_FULL; rhand_d = '0; rpay_d = '0; state_d = ST_RESP;
            end else begin
              idx_d = free_q[IdxW-1:0];
              dly_d = s_axis_tdata_i[DelayBits-1:0];
              pay_d = s_axis_tdata_i[DelayBits +: 32];
              state_d = ST_SET;
            end
          end else begin
            prev_d = Nil; steps_d = '0; held_d = 1'b0; state_d = ST_HEAD_RD;
          end
        end
      end
      ST_SET: begin
        free_d = free_link;
        if (StepW'(idx_q) >= fill_q) fill_d = StepW'(idx_q) + StepW'(1);
        ewe = 1'b1;
        ewd.link = pend_q; ewd.rounds = dly_q; ewd.payload = pay_q;
        pend_d = LinkW'(idx_q);
        rkind_d = KIND_SET; rhand_d = idx_q; rpay_d = '0;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = rkind_q; ohand_d = 6'(rhand_q); opay_d = rpay_q;
          olast_d = 1'b1; state_d = ST_IDLE;
        end
      end
      ST_HEAD_RD: begin
        cur_d = srd; idx_d = srd[IdxW-1:0]; era = srd[IdxW-1:0];
        if (srd >= Nil) begin
          pos_d = pos_n; steps_d = '0; state_d = ST_PEND_RD;
        end else begin
          state_d = ST_WALK_WR;
        end
      end
      ST_WALK_RD: begin
        era = cur_q[IdxW-1:0]; idx_d = cur_q[IdxW-1:0]; state_d = ST_WALK_WR;
      end
      ST_WALK_WR: begin
        if (erd.rounds == '0) begin
          // Expiry: the held result goes out first, so the walk waits for room.
          if (!held_q || out_free) begin
            if (held_q) begin
              ov_d = 1'b1; okind_d = rkind_q; ohand_d = 6'(rhand_q); opay_d = rpay_q;
              olast_d = 1'b0;
            end
            held_d = 1'b1; rkind_d = KIND_EXPIRED; rhand_d = idx_q; rpay_d = erd.payload;
            ewe = 1'b1; ewd.link = free_q;
            free_d = LinkW'(idx_q);
            if (prev_q >= Nil) begin
              swe = 1'b1; swa = pos_q; swd = erd.link;
            end
            walk_go = 1'b1;
          end
        end else begin
          ewe = 1'b1; ewd.rounds = erd.rounds - DelayBits'(1);
          prev_d = LinkW'(idx_q);
          rec_d = erd; rec_d.rounds = erd.rounds - DelayBits'(1);
          walk_go = 1'b1;
        end
        if (walk_go) begin
          steps_d = steps_q + StepW'(1); cur_d = erd.link;
          if (erd.rounds == '0 && prev_q < Nil) begin
            state_d = ST_UNLINK;
          end else if (steps_q + StepW'(1) >= StepW'(Entries) || erd.link >= Nil) begin
            pos_d = pos_n; steps_d = '0; state_d = ST_PEND_RD;
          end else begin
            state_d = ST_WALK_RD;
          end
        end
      end
      ST_UNLINK: begin
        // The kept predecessor now points past the expired entry.
        ewe = 1'b1; ewa = prev_q[IdxW-1:0]; ewd = rec_q; ewd.link = cur_q;
        rec_d.link = cur_q;
        if (steps_q >= StepW'(Entries) || cur_q >= Nil) begin
          pos_d = pos_n; steps_d = '0; state_d = ST_PEND_RD;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_PEND_RD: begin
        era = pend_q[IdxW-1:0]; idx_d = pend_q[IdxW-1:0];
        if (pend_q >= Nil || steps_q >= StepW'(Entries)) begin
          pend_d = Nil;
          if (!held_q) begin
            rkind_d = KIND_QUIET; rhand_d = '0; rpay_d = '0;
          end
          state_d = ST_RESP;
        end else begin
          state_d = ST_PEND_HD;
        end
      end
      ST_PEND_HD: begin
        rec_d = erd; tgt_d = tgt_n; sra = tgt_n; state_d = ST_PEND_WR;
      end
      ST_PEND_WR: begin
        ewe = 1'b1; ewd = rec_q; ewd.link = srd;
        ewd.rounds = DelayBits'(rec_q.rounds >> SlotW);
        swe = 1'b1; swa = tgt_q; swd = LinkW'(idx_q);
        pend_d = rec_q.link; steps_d = steps_q + StepW'(1); state_d = ST_PEND_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; pos_q <= '0; tgt_q <= '0;
      pend_q <= Nil; free_q <= '0; cur_q <= Nil; prev_q <= Nil;
      steps_q <= '0; fill_q <= '0; idx_q <= '0; dly_q <= '0; pay_q <= '0;
      rec_q <= '0; held_q <= 1'b0; rkind_q <= KIND_QUIET; rhand_q <= '0; rpay_q <= '0;
      ov_q <= 1'b0; okind_q <= KIND_QUIET; ohand_q <= '0; opay_q <= '0; olast_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; pos_q <= pos_d; tgt_q <= tgt_d;
      pend_q <= pend_d; free_q <= free_d; cur_q <= cur_d; prev_q <= prev_d;
      steps_q <= steps_d; fill_q <= fill_d; idx_q <= idx_d; dly_q <= dly_d;
      pay_q <= pay_d;
      rec_q <= rec_d; held_q <= held_d; rkind_q <= rkind_d; rhand_q <= rhand_d;
      rpay_q <= rpay_d;
      ov_q <= ov_d; okind_q <= okind_d; ohand_q <= ohand_d; opay_q <= opay_d;
      olast_q <= olast_d;
    end
  end
endmodule

@@ hw/rtl/htw_checker.sv @@
module htw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import htw_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_set_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_SET || m_axis_tuser_o == KIND_FULL)
      |-> m_axis_tlast_o)
    else $error("set result without last");

  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_QUIET |-> m_axis_tdata_o == '0)
    else $error("quiet tick carries data");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request taken while one is in progress");
endmodule

bind hashed_timing_wheel htw_checker u_htw_checker (.*);
